/* rtl/four_bit_mcu_data_unit_defines.svh */
// Assertion macros for the four-bit MCU data unit.
// Used by the top level; depends on nothing.
`ifndef FOUR_BIT_MCU_DATA_UNIT_DEFINES_SVH
`define FOUR_BIT_MCU_DATA_UNIT_DEFINES_SVH
`define FBM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FBM_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/fbm_pkg.sv */
// Package for the four-bit MCU data unit: payload types and command codes.
// No dependencies.
package fbm_pkg;
    localparam logic [5:0] CMD_LB = 6'd0, CMD_INCB = 6'd1, CMD_DECB = 6'd2, CMD_SBM = 6'd3,
        CMD_RBM = 6'd4, CMD_EXC = 6'd5, CMD_EXCI = 6'd6, CMD_EXCD = 6'd7, CMD_LBL = 6'd8,
        CMD_EXBLA = 6'd9, CMD_LDA = 6'd10, CMD_LAX = 6'd11, CMD_ATR = 6'd12,
        CMD_ADD = 6'd13, CMD_ADD11 = 6'd14, CMD_ADX = 6'd15, CMD_COMA = 6'd16,
        CMD_RC = 6'd17, CMD_SC = 6'd18, CMD_TC = 6'd19, CMD_TAM = 6'd20, CMD_TMI = 6'd21,
        CMD_TA0 = 6'd22, CMD_TABL = 6'd23, CMD_RM = 6'd24, CMD_SM = 6'd25,
        CMD_RMF = 6'd26, CMD_SMF = 6'd27, CMD_COMCN = 6'd28, CMD_ATBP = 6'd29,
        CMD_KTA = 6'd30, CMD_TAL = 6'd31, CMD_TB = 6'd32, CMD_DTW = 6'd33,
        CMD_PDTW = 6'd34, CMD_WR = 6'd35, CMD_WS = 6'd36, CMD_TW = 6'd37, CMD_PTW = 6'd38;

    typedef enum logic {ST_IDLE, ST_EXEC} t_state;

    typedef struct packed {
        logic [5:0] cmd;
        logic [7:0] opcode;
        logic [7:0] second_byte;
        logic [3:0] key_value;
        logic       ba_pin;
        logic       beta_pin;
    } t_in;

    typedef struct packed {
        logic [3:0]  acc_out;
        logic        carry_out;
        logic        skip_next;
        logic [3:0]  ptr_low_out;
        logic [2:0]  ptr_mid_out;
        logic [3:0]  r_out;
        logic        bp_out;
        logic [35:0] segment_latches;
    } t_out;

    function automatic logic [3:0] digit_rom(input logic [4:0] idx);
        logic [3:0] d;
        case (idx)
            5'd0: d = 4'he;  5'd1: d = 4'h0;  5'd2: d = 4'hc;  5'd3: d = 4'h8;
            5'd4: d = 4'h2;  5'd5: d = 4'ha;  5'd6: d = 4'he;  5'd7: d = 4'h2;
            5'd8: d = 4'he;  5'd9: d = 4'ha;  5'd10: d = 4'h0; 5'd11: d = 4'h0;
            5'd12: d = 4'h2; 5'd13: d = 4'ha; 5'd14: d = 4'h2; 5'd15: d = 4'h2;
            5'd16: d = 4'hb; 5'd17: d = 4'h9; 5'd18: d = 4'h7; 5'd19: d = 4'hf;
            5'd20: d = 4'hd; 5'd21: d = 4'he; 5'd22: d = 4'he; 5'd23: d = 4'hb;
            5'd24: d = 4'hf; 5'd25: d = 4'hf; 5'd26: d = 4'h4; 5'd27: d = 4'h0;
            5'd28: d = 4'hd; 5'd29: d = 4'he; 5'd30: d = 4'h4; 5'd31: d = 4'h0;
            default: d = 4'h0;
        endcase
        return d;
    endfunction
endpackage

/* rtl/four_bit_mcu_data_unit.sv */
// Four-bit MCU data unit: executes one non-branch instruction per item.
// An accepted item is registered, executed in the EXEC state, and its result registered to
// the output. No new item is taken while one is in EXEC, as set by the single data RAM read
// followed by its write-back, nor while a result waits under an output stall. After reset
// a clearing pass zeroes the data RAM; no item is taken until it ends. Configuration writes
// are taken at any time. Depends on fbm_pkg and four_bit_mcu_data_unit_defines.svh.
`include "four_bit_mcu_data_unit_defines.svh"
module four_bit_mcu_data_unit
    import fbm_pkg::*;
#(
    parameter int OUT_PINS  = 9,
    parameter int RAM_WORDS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);
    localparam int AW = $clog2(RAM_WORDS);

    logic [3:0] r_mem [RAM_WORDS];
    logic [3:0] r_rd;
    logic [AW:0] r_clr, n_clr;
    logic r_clearing, n_clearing;
    t_state r_state, n_state;
    t_in r_item;
    logic [6:0] r_mask;
    logic [3:0] r_acc, n_acc, r_low, n_low, r_r, n_r;
    logic [2:0] r_mid, n_mid;
    logic r_c, n_c, r_bp, n_bp, r_cn, n_cn, r_mx, n_mx;
    logic [7:0] r_last;
    logic [3:0] r_stg [OUT_PINS];
    logic [3:0] n_stg [OUT_PINS];
    logic [3:0] r_pin [OUT_PINS];
    logic [3:0] n_pin [OUT_PINS];
    logic r_ov;
    t_out r_out, n_out;
    logic accept, exec, wr_en;
    logic [3:0] wr_val, ram_v, bitm, dig;
    logic [6:0] addr;
    logic in_range, skip;
    logic [4:0] sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_clearing || r_state != ST_IDLE || (r_ov && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign exec        = r_state == ST_EXEC;
    assign addr        = {r_mid, r_low} & r_mask;
    assign in_range    = {1'b0, addr} < 8'(RAM_WORDS);
    assign ram_v       = in_range ? r_rd : 4'h0;
    assign bitm        = 4'b1 << r_item.opcode[1:0];
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr + 1'b1;
        n_clearing = r_clearing && (r_clr != (AW + 1)'(RAM_WORDS - 1));
    end

    always_comb begin
        n_acc = r_acc; n_c = r_c; n_low = r_low; n_mid = r_mid; n_r = r_r;
        n_bp = r_bp; n_cn = r_cn; n_mx = r_mx; n_stg = r_stg; n_pin = r_pin;
        skip = 1'b0; wr_en = 1'b0; wr_val = r_acc; sum = 5'd0;
        dig = digit_rom({r_cn, r_acc}) | {3'b0, !r_cn && r_mx};
        case (r_item.cmd)
            CMD_LB: begin
                n_mid = {1'b0, r_item.opcode[1:0]};
                n_low = {|r_item.opcode[3:2], 1'b0, r_item.opcode[3:2]};
            end
            CMD_INCB: begin n_low = r_low + 4'd1; skip = n_low == 4'd8; end
            CMD_DECB: begin n_low = r_low - 4'd1; skip = n_low == 4'hf; end
            CMD_SBM: n_mid = r_mid | 3'd4;
            CMD_RBM: n_mid = r_mid & 3'd3;
            CMD_EXC, CMD_EXCI, CMD_EXCD: begin
                n_acc = ram_v; wr_en = 1'b1; wr_val = r_acc;
                n_mid = r_mid ^ {1'b0, r_item.opcode[1:0]};
                if (r_item.cmd == CMD_EXCI) begin
                    n_low = r_low + 4'd1; skip = n_low == 4'd8;
                end else if (r_item.cmd == CMD_EXCD) begin
                    n_low = r_low - 4'd1; skip = n_low == 4'hf;
                end
            end
            CMD_LBL: begin
                n_low = r_item.second_byte[3:0];
                n_mid = r_item.second_byte[6:4] & r_mask[6:4];
            end
            CMD_EXBLA: begin n_acc = r_low; n_low = r_acc; end
            CMD_LDA: begin
                n_acc = ram_v; n_mid = r_mid ^ {1'b0, r_item.opcode[1:0]};
            end
            CMD_LAX: if (r_item.opcode[7:4] != r_last[7:4]) n_acc = r_item.opcode[3:0];
            CMD_ATR: n_r = r_acc;
            CMD_ADD: n_acc = r_acc + ram_v;
            CMD_ADD11: begin
                sum = {1'b0, r_acc} + {1'b0, ram_v} + {4'b0, r_c};
                n_c = sum[4]; skip = sum[4]; n_acc = sum[3:0];
            end
            CMD_ADX: begin
                sum = {1'b0, r_acc} + {1'b0, r_item.opcode[3:0]};
                skip = r_item.opcode[3:0] != 4'd10 && sum[4]; n_acc = sum[3:0];
            end
            CMD_COMA: n_acc = ~r_acc;
            CMD_RC: n_c = 1'b0;
            CMD_SC: n_c = 1'b1;
            CMD_TC: skip = !r_c;
            CMD_TAM: skip = r_acc == ram_v;
            CMD_TMI: skip = |(ram_v & bitm);
            CMD_TA0: skip = r_acc == 4'd0;
            CMD_TABL: skip = r_acc == r_low;
            CMD_RM: begin wr_en = 1'b1; wr_val = ram_v & ~bitm; end
            CMD_SM: begin wr_en = 1'b1; wr_val = ram_v | bitm; end
            CMD_RMF: begin n_mx = 1'b0; n_acc = 4'd0; end
            CMD_SMF: n_mx = 1'b1;
            CMD_COMCN: n_cn = !r_cn;
            CMD_ATBP: begin n_bp = r_acc[0]; n_cn = r_acc[3]; end
            CMD_KTA: n_acc = r_item.key_value;
            CMD_TAL: skip = r_item.ba_pin;
            CMD_TB: skip = r_item.beta_pin;
            CMD_DTW, CMD_WR, CMD_WS: begin
                for (int i = 0; i < OUT_PINS - 1; i++) n_stg[i] = r_stg[i + 1];
                n_stg[OUT_PINS - 1] = r_item.cmd == CMD_DTW ? dig :
                    r_item.cmd == CMD_WR ? {1'b0, r_acc[2:0]} : {1'b1, r_acc[2:0]};
            end
            CMD_PDTW: begin
                n_stg[OUT_PINS - 2] = r_stg[OUT_PINS - 1];
                n_stg[OUT_PINS - 1] = dig;
            end
            CMD_TW: n_pin = r_stg;
            CMD_PTW: begin
                n_pin[OUT_PINS - 1] = r_stg[OUT_PINS - 1];
                n_pin[OUT_PINS - 2] = r_stg[OUT_PINS - 2];
            end
            default: ;
        endcase
        n_out = '0;
        n_out.acc_out = n_acc; n_out.carry_out = n_c; n_out.skip_next = skip;
        n_out.ptr_low_out = n_low; n_out.ptr_mid_out = n_mid; n_out.r_out = n_r;
        n_out.bp_out = n_bp;
        for (int i = 0; i < OUT_PINS && i < 9; i++) n_out.segment_latches[4 * i +: 4] = n_pin[i];
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr[AW-1:0]] <= 4'h0;
        end else if (exec && wr_en && in_range) begin
            r_mem[addr[AW-1:0]] <= wr_val;
        end
        r_rd <= r_mem[addr[AW-1:0]];
        if (accept) r_item <= i_in_data;
        if (exec) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_clearing <= 1'b1; r_clr <= '0; r_mask <= 7'h7f;
            r_acc <= '0; r_c <= 1'b0; r_low <= '0; r_mid <= '0; r_r <= '0;
            r_bp <= 1'b0; r_cn <= 1'b0; r_mx <= 1'b0; r_last <= '0; r_ov <= 1'b0;
            for (int i = 0; i < OUT_PINS; i++) begin r_stg[i] <= '0; r_pin[i] <= '0; end
        end else begin
            r_state <= n_state;
            if (r_clearing) begin r_clr <= n_clr; r_clearing <= n_clearing; end
            if (i_cfg_valid) r_mask <= i_cfg_data;
            if (exec) begin
                r_acc <= n_acc; r_c <= n_c; r_low <= n_low; r_mid <= n_mid; r_r <= n_r;
                r_bp <= n_bp; r_cn <= n_cn; r_mx <= n_mx; r_last <= r_item.opcode;
                r_stg <= n_stg; r_pin <= n_pin;
            end
            if (exec) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    `FBM_ASSERT(a_no_accept_clear, i_clk, i_rst_n, r_clearing |-> !accept, "accept during clear")
    `FBM_ASSERT(a_exec_one, i_clk, i_rst_n, accept |=> exec, "accept not followed by exec")
    `FBM_ASSERT(a_exec_out, i_clk, i_rst_n, exec |=> r_ov, "exec gave no result")
    `FBM_ASSERT_RST(a_rst, i_clk, !i_rst_n |=> !r_ov && r_state == ST_IDLE, "reset state")
endmodule

/* verif/tb.sv */
// Testbench for the four-bit MCU data unit: directed and random instruction items
// checked against a scoreboard that predicts every register and latch.
// Depends on fbm_pkg and four_bit_mcu_data_unit.
`timescale 1ns / 100ps

class mcu_scoreboard;
    logic [6:0] addr_mask;
    logic [3:0] acc, ptr_low, r_reg;
    logic [2:0] ptr_mid;
    logic       carry, bp, cn, mx;
    logic [3:0] ram [128];
    logic [3:0] stage [9];
    logic [3:0] pins [9];
    logic [7:0] prev_op;
    fbm_pkg::t_out pending[$];
    int errors;

    function void clear();
        addr_mask = 7'h7f;
        acc = '0; ptr_low = '0; r_reg = '0; ptr_mid = '0;
        carry = 1'b0; bp = 1'b0; cn = 1'b0; mx = 1'b0; prev_op = '0;
        foreach (ram[i]) ram[i] = '0;
        foreach (stage[i]) begin
            stage[i] = '0;
            pins[i] = '0;
        end
        errors = 0;
    endfunction

    function logic [6:0] addr();
        return {ptr_mid, ptr_low} & addr_mask;
    endfunction

    function logic [3:0] digit();
        logic [4:0] idx;
        logic [3:0] tbl [32];
        tbl = '{4'he, 4'h0, 4'hc, 4'h8, 4'h2, 4'ha, 4'he, 4'h2,
                4'he, 4'ha, 4'h0, 4'h0, 4'h2, 4'ha, 4'h2, 4'h2,
                4'hb, 4'h9, 4'h7, 4'hf, 4'hd, 4'he, 4'he, 4'hb,
                4'hf, 4'hf, 4'h4, 4'h0, 4'hd, 4'he, 4'h4, 4'h0};
        idx = {cn, acc};
        return cn ? tbl[idx] : (tbl[idx] | {3'b0, mx});
    endfunction

    function void shift_stage();
        for (int i = 0; i < 8; i++) stage[i] = stage[i + 1];
    endfunction

    function void swap_acc(logic [7:0] op);
        logic [3:0] t;
        t = acc;
        acc = ram[addr()];
        ram[addr()] = t;
        ptr_mid = ptr_mid ^ {1'b0, op[1:0]};
    endfunction

    function void note_item(fbm_pkg::t_in it);
        logic [3:0] bitm, m;
        logic [4:0] sum;
        logic       skip;
        fbm_pkg::t_out res;
        bitm = 4'b1 << it.opcode[1:0];
        m = ram[addr()];
        skip = 1'b0;
        case (it.cmd)
            fbm_pkg::CMD_LB: begin
                ptr_mid = {1'b0, it.opcode[1:0]};
                ptr_low = {|it.opcode[3:2], 1'b0, it.opcode[3:2]};
            end
            fbm_pkg::CMD_INCB: begin
                ptr_low++;
                skip = ptr_low == 4'd8;
            end
            fbm_pkg::CMD_DECB: begin
                ptr_low--;
                skip = ptr_low == 4'hf;
            end
            fbm_pkg::CMD_SBM: ptr_mid[2] = 1'b1;
            fbm_pkg::CMD_RBM: ptr_mid[2] = 1'b0;
            fbm_pkg::CMD_EXC: swap_acc(it.opcode);
            fbm_pkg::CMD_EXCI: begin
                swap_acc(it.opcode);
                ptr_low++;
                skip = ptr_low == 4'd8;
            end
            fbm_pkg::CMD_EXCD: begin
                swap_acc(it.opcode);
                ptr_low--;
                skip = ptr_low == 4'hf;
            end
            fbm_pkg::CMD_LBL: begin
                ptr_low = it.second_byte[3:0];
                ptr_mid = it.second_byte[6:4] & addr_mask[6:4];
            end
            fbm_pkg::CMD_EXBLA: begin
                m = acc;
                acc = ptr_low;
                ptr_low = m;
            end
            fbm_pkg::CMD_LDA: begin
                acc = m;
                ptr_mid = ptr_mid ^ {1'b0, it.opcode[1:0]};
            end
            fbm_pkg::CMD_LAX: if (it.opcode[7:4] != prev_op[7:4]) acc = it.opcode[3:0];
            fbm_pkg::CMD_ATR: r_reg = acc;
            fbm_pkg::CMD_ADD: acc = acc + m;
            fbm_pkg::CMD_ADD11: begin
                sum = {1'b0, acc} + {1'b0, m} + {4'b0, carry};
                carry = sum[4];
                skip = sum[4];
                acc = sum[3:0];
            end
            fbm_pkg::CMD_ADX: begin
                sum = {1'b0, acc} + {1'b0, it.opcode[3:0]};
                skip = it.opcode[3:0] != 4'd10 && sum[4];
                acc = sum[3:0];
            end
            fbm_pkg::CMD_COMA: acc = ~acc;
            fbm_pkg::CMD_RC: carry = 1'b0;
            fbm_pkg::CMD_SC: carry = 1'b1;
            fbm_pkg::CMD_TC: skip = !carry;
            fbm_pkg::CMD_TAM: skip = acc == m;
            fbm_pkg::CMD_TMI: skip = |(m & bitm);
            fbm_pkg::CMD_TA0: skip = acc == 4'd0;
            fbm_pkg::CMD_TABL: skip = acc == ptr_low;
            fbm_pkg::CMD_RM: ram[addr()] = m & ~bitm;
            fbm_pkg::CMD_SM: ram[addr()] = m | bitm;
            fbm_pkg::CMD_RMF: begin
                mx = 1'b0;
                acc = '0;
            end
            fbm_pkg::CMD_SMF: mx = 1'b1;
            fbm_pkg::CMD_COMCN: cn = !cn;
            fbm_pkg::CMD_ATBP: begin
                bp = acc[0];
                cn = acc[3];
            end
            fbm_pkg::CMD_KTA: acc = it.key_value;
            fbm_pkg::CMD_TAL: skip = it.ba_pin;
            fbm_pkg::CMD_TB: skip = it.beta_pin;
            fbm_pkg::CMD_DTW: begin
                shift_stage();
                stage[8] = digit();
            end
            fbm_pkg::CMD_PDTW: begin
                stage[7] = stage[8];
                stage[8] = digit();
            end
            fbm_pkg::CMD_WR: begin
                shift_stage();
                stage[8] = {1'b0, acc[2:0]};
            end
            fbm_pkg::CMD_WS: begin
                shift_stage();
                stage[8] = acc | 4'h8;
            end
            fbm_pkg::CMD_TW: foreach (pins[i]) pins[i] = stage[i];
            fbm_pkg::CMD_PTW: begin
                pins[8] = stage[8];
                pins[7] = stage[7];
            end
            default: ;
        endcase
        prev_op = it.opcode;
        res.acc_out = acc;
        res.carry_out = carry;
        res.skip_next = skip;
        res.ptr_low_out = ptr_low;
        res.ptr_mid_out = ptr_mid;
        res.r_out = r_reg;
        res.bp_out = bp;
        for (int i = 0; i < 9; i++) res.segment_latches[4 * i +: 4] = pins[i];
        pending.push_back(res);
    endfunction

    function void check_result(fbm_pkg::t_out got);
        fbm_pkg::t_out exp_res;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        if (got.acc_out !== exp_res.acc_out)
            report("acc", 36'(exp_res.acc_out), 36'(got.acc_out));
        if (got.carry_out !== exp_res.carry_out)
            report("carry", 36'(exp_res.carry_out), 36'(got.carry_out));
        if (got.skip_next !== exp_res.skip_next)
            report("skip", 36'(exp_res.skip_next), 36'(got.skip_next));
        if (got.ptr_low_out !== exp_res.ptr_low_out)
            report("ptr_low", 36'(exp_res.ptr_low_out), 36'(got.ptr_low_out));
        if (got.ptr_mid_out !== exp_res.ptr_mid_out)
            report("ptr_mid", 36'(exp_res.ptr_mid_out), 36'(got.ptr_mid_out));
        if (got.r_out !== exp_res.r_out)
            report("r", 36'(exp_res.r_out), 36'(got.r_out));
        if (got.bp_out !== exp_res.bp_out)
            report("bp", 36'(exp_res.bp_out), 36'(got.bp_out));
        if (got.segment_latches !== exp_res.segment_latches)
            report("latches", exp_res.segment_latches, got.segment_latches);
    endfunction

    function void report(string field, logic [35:0] exp_val, logic [35:0] act_val);
        $display("%0t: %s expected %h actual %h", $time, field, exp_val, act_val);
        errors++;
    endfunction
endclass

module tb;
    import fbm_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in        in_data;
    logic       out_valid;
    logic       out_stall;
    t_out       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;
    mcu_scoreboard sb;
    int         stall_cnt;

    four_bit_mcu_data_unit DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_item(t_in it);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
    endtask

    task automatic write_mask(logic [6:0] value);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.addr_mask = value;
    endtask

    function automatic t_in rand_item(logic [5:0] cmd);
        t_in it;
        it.cmd = cmd;
        it.opcode = 8'($urandom);
        it.second_byte = 8'($urandom);
        it.key_value = 4'($urandom);
        it.ba_pin = 1'($urandom);
        it.beta_pin = 1'($urandom);
        return it;
    endfunction

    // Skews the mix toward commands that write memory and fill the display latches.
    function automatic logic [5:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 6'($urandom_range(40, 63));
        if (r < 20) return 6'(CMD_EXC + $urandom_range(0, 2));
        if (r < 30) return 6'(CMD_DTW + $urandom_range(0, 5));
        return 6'($urandom_range(0, 39));
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_data);
            if (stall_cnt != 0) begin
                out_stall <= 1'b1;
                stall_cnt--;
            end else begin
                out_stall <= 1'b0;
                stall_cnt = gap_len();
            end
        end
    end

    initial begin
        t_in it;
        logic [6:0] masks [4];
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        it = '0;
        for (int c = 0; c < 40; c++) begin
            it = rand_item(c[5:0]);
            if (c < 20) it.opcode = (c % 2) ? 8'hff : 8'h00;
            send_item(it);
        end
        it = rand_item(6'd63);
        send_item(it);
        masks = '{7'h00, 7'h0f, 7'h55, 7'h7f};
        foreach (masks[p]) begin
            write_mask(masks[p]);
            for (int n = 0; n < 190; n++) begin
                it = rand_item(pick_cmd());
                send_item(it);
            end
        end
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/fbm_pkg.sv
rtl/four_bit_mcu_data_unit.sv
verif/tb.sv
